// ===== design/cubic_hermite_knot_interpolator_unit_defines.svh =====
// assertion macros for the rtl files; only chki_ctrl includes them
`ifndef CUBIC_HERMITE_KNOT_INTERPOLATOR_UNIT_DEFINES_SVH
`define CUBIC_HERMITE_KNOT_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CHKI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHKI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/chki_pkg.sv =====
package chki_pkg;

  // action codes carried on in_tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] RS_INTERP = 2'd0;
  localparam logic [1:0] RS_BELOW  = 2'd1;
  localparam logic [1:0] RS_ABOVE  = 2'd2;
  localparam logic [1:0] RS_ZERO   = 2'd3;

  // divider working width: 34-bit magnitude shifted by up to 31 places
  localparam int DIVW = 65;

  // datapath command codes
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_WRITE    = 5'd1;
  localparam logic [4:0] OP_LOAD     = 5'd2;
  localparam logic [4:0] OP_RD_LAST  = 5'd3;
  localparam logic [4:0] OP_CAP_LAST = 5'd4;
  localparam logic [4:0] OP_CHECK    = 5'd5;
  localparam logic [4:0] OP_SCAN_RD  = 5'd6;
  localparam logic [4:0] OP_SCAN_CMP = 5'd7;
  localparam logic [4:0] OP_SETUP    = 5'd8;
  localparam logic [4:0] OP_FETCH    = 5'd9;
  localparam logic [4:0] OP_DIFF     = 5'd10;
  localparam logic [4:0] OP_ZCHK     = 5'd11;
  localparam logic [4:0] OP_DIV_LD   = 5'd12;
  localparam logic [4:0] OP_DIV_STEP = 5'd13;
  localparam logic [4:0] OP_DIV_END  = 5'd14;
  localparam logic [4:0] OP_MUL_A    = 5'd15;
  localparam logic [4:0] OP_MUL_B    = 5'd16;
  localparam logic [4:0] OP_BASIS    = 5'd17;
  localparam logic [4:0] OP_FINAL    = 5'd18;
  localparam logic [4:0] OP_EMIT     = 5'd19;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic below;
    logic above;
    logic match;
    logic scan_end;
    logic eq_last;
    logic zero_den;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/chki_ctrl.sv =====
`include "cubic_hermite_knot_interpolator_unit_defines.svh"
module chki_ctrl import chki_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RD_LAST  = 5'd1;
  localparam logic [4:0] S_CAP_LAST = 5'd2;
  localparam logic [4:0] S_CHECK    = 5'd3;
  localparam logic [4:0] S_SCAN_RD  = 5'd4;
  localparam logic [4:0] S_SCAN_CMP = 5'd5;
  localparam logic [4:0] S_SETUP    = 5'd6;
  localparam logic [4:0] S_FETCH    = 5'd7;
  localparam logic [4:0] S_DIFF     = 5'd8;
  localparam logic [4:0] S_ZCHK     = 5'd9;
  localparam logic [4:0] S_DIV_LD   = 5'd10;
  localparam logic [4:0] S_DIV_STEP = 5'd11;
  localparam logic [4:0] S_DIV_END  = 5'd12;
  localparam logic [4:0] S_MUL_A    = 5'd13;
  localparam logic [4:0] S_MUL_B    = 5'd14;
  localparam logic [4:0] S_BASIS    = 5'd15;
  localparam logic [4:0] S_FINAL    = 5'd16;
  localparam logic [4:0] S_EMIT     = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == ACT_QUERY) begin
            cmd.op    = OP_LOAD;
            state_nxt = S_RD_LAST;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_RD_LAST: begin
        cmd.op    = OP_RD_LAST;
        state_nxt = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd.op    = OP_CAP_LAST;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = (sts.below || sts.above) ? S_EMIT : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.op    = OP_SCAN_RD;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.op = OP_SCAN_CMP;
        priority if (sts.match) state_nxt = S_SETUP;
        else if (sts.scan_end) state_nxt = sts.eq_last ? S_EMIT : S_SETUP;
        else state_nxt = S_SCAN_RD;
      end
      S_SETUP: begin
        cmd.op    = OP_SETUP;
        sel_nxt   = 3'd0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.op = OP_FETCH;
        if (sel_r == 3'd4) state_nxt = S_DIFF;
        else sel_nxt = sel_r + 3'd1;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        cmd.op  = OP_ZCHK;
        sel_nxt = 3'd0;
        state_nxt = sts.zero_den ? S_EMIT : S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.op    = OP_DIV_LD;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.op = OP_DIV_END;
        if (sel_r == 3'd2) begin
          sel_nxt   = 3'd0;
          state_nxt = S_MUL_A;
        end else begin
          sel_nxt   = sel_r + 3'd1;
          state_nxt = S_DIV_LD;
        end
      end
      S_MUL_A: begin
        cmd.op    = OP_MUL_A;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op  = OP_MUL_B;
        sel_nxt = sel_r + 3'd1;
        priority if (sel_r == 3'd3) state_nxt = S_BASIS;
        else if (sel_r == 3'd7) state_nxt = S_FINAL;
        else state_nxt = S_MUL_A;
      end
      S_BASIS: begin
        cmd.op    = OP_BASIS;
        state_nxt = S_MUL_A;
      end
      S_FINAL: begin
        cmd.op    = OP_FINAL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 3'd0;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `CHKI_ASSERT_NXT(a_idle_hold, state_r == S_IDLE && !in_tvalid, state_r == S_IDLE, "idle left without a word")
  `CHKI_ASSERT_NXT(a_emit_done, state_r == S_EMIT && sts.out_free, state_r == S_IDLE, "emit did not return to idle")
  `CHKI_ASSERT_IMP(a_fetch_sel, state_r == S_FETCH, sel_r <= 3'd4, "fetch slot out of range")
  `CHKI_ASSERT_IMP(a_div_sel, state_r == S_DIV_LD || state_r == S_DIV_END, sel_r <= 3'd2, "divide select out of range")

endmodule

// ===== design/chki_dp.sv =====
module chki_dp import chki_pkg::*; #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic         cfg_valid,
  input  logic [6:0]   cfg_data,
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata
);

  localparam int IW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int NW = IW + 1;
  localparam int CW = (NW > 7) ? NW : 7;

  logic [6:0] kc_r;
  logic [5:0] w_idx;
  logic signed [31:0] w_time, w_val, w_q;
  assign w_idx  = in_tdata[5:0];
  assign w_time = in_tdata[37:6];
  assign w_val  = in_tdata[69:38];
  assign w_q    = in_tdata[101:70];

  // clamp the knot count into the table
  logic [CW-1:0] kce, ncl;
  logic [NW-1:0] n_c;
  always_comb begin
    kce = CW'(kc_r);
    if (kce < CW'(2)) ncl = CW'(2);
    else if (kce > CW'(MAX_KNOTS)) ncl = CW'(MAX_KNOTS);
    else ncl = kce;
    n_c = ncl[NW-1:0];
  end

  logic signed [31:0] mem_t [MAX_KNOTS];
  logic signed [31:0] mem_v [MAX_KNOTS];
  logic signed [31:0] rd_t_r, rd_v_r;
  logic [NW-1:0] ra;
  logic wr_ok;

  logic [NW-1:0] n_r, i_r, a_r, b_r, c_r, d_r;
  logic wrap_r, found_r;
  logic signed [31:0] tq_r, tf_r, vf_r, tl_r, vl_r, prev_r;
  logic signed [31:0] t0_r, t1_r, t2_r, y0_r, y1_r, y2_r, y3_r;
  logic signed [32:0] t3_r;
  logic signed [33:0] h_r, e_r, g_r;
  logic signed [31:0] res_v_r;
  logic [1:0] res_s_r;

  assign wr_ok = ({26'd0, w_idx} < 32'(MAX_KNOTS));

  always_comb begin
    unique case (cmd.op)
      OP_RD_LAST: ra = n_r - NW'(1);
      OP_SCAN_RD: ra = i_r + NW'(1);
      OP_FETCH: begin
        unique case (cmd.sel)
          3'd0:    ra = a_r;
          3'd1:    ra = b_r;
          3'd2:    ra = c_r;
          default: ra = d_r;
        endcase
      end
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_ok) begin
      mem_t[IW'(w_idx)] <= w_time;
      mem_v[IW'(w_idx)] <= w_val;
    end
    rd_t_r <= mem_t[ra[IW-1:0]];
    rd_v_r <= mem_v[ra[IW-1:0]];
  end

  // divider operands
  logic signed [33:0] num_c, den_c;
  logic [33:0] nmag, dmag;
  logic [DIVW-1:0] dd_c;
  logic [DIVW-1:0] rem_r, vs_r;
  logic [31:0] q_r;
  logic dneg_r, dovf_r;
  logic signed [31:0] div_res;
  logic signed [31:0] x_r, m1_r, m2_r;

  always_comb begin
    unique case (cmd.sel)
      3'd0: begin
        num_c = 34'(tq_r) - 34'(t1_r);
        den_c = h_r;
      end
      3'd1: begin
        num_c = 34'(y2_r) - 34'(y0_r);
        den_c = e_r;
      end
      default: begin
        num_c = 34'(y3_r) - 34'(y1_r);
        den_c = g_r;
      end
    endcase
    nmag = num_c[33] ? 34'(-num_c) : 34'(num_c);
    dmag = den_c[33] ? 34'(-den_c) : 34'(den_c);
    dd_c = DIVW'(nmag) << FRAC_BITS;
  end

  always_comb begin
    if (dovf_r) div_res = dneg_r ? 32'sh80000000 : 32'sh7fffffff;
    else if (!dneg_r) div_res = q_r[31] ? 32'sh7fffffff : signed'(q_r);
    else div_res = (q_r > 32'h80000000) ? 32'sh80000000 : signed'(32'(-q_r));
  end

  // multiplier operands
  logic signed [33:0] ma;
  logic signed [31:0] mb;
  logic [33:0] amag;
  logic [31:0] bmag;
  logic [65:0] pr_r;
  logic mneg_r;
  logic [65:0] psh;
  logic [32:0] lim, pc;
  logic signed [31:0] mres;
  logic signed [31:0] x2_r, x3_r, d1_r, d2_r, b00_r, b10_r, b01_r, b11_r;
  logic signed [33:0] acc_r;

  always_comb begin
    unique case (cmd.sel)
      3'd0: begin ma = 34'(x_r);   mb = x_r;  end
      3'd1: begin ma = 34'(x2_r);  mb = x_r;  end
      3'd2: begin ma = h_r;        mb = m1_r; end
      3'd3: begin ma = h_r;        mb = m2_r; end
      3'd4: begin ma = 34'(b00_r); mb = y1_r; end
      3'd5: begin ma = 34'(b10_r); mb = d1_r; end
      3'd6: begin ma = 34'(b01_r); mb = y2_r; end
      default: begin ma = 34'(b11_r); mb = d2_r; end
    endcase
    amag = ma[33] ? 34'(-ma) : 34'(ma);
    bmag = mb[31] ? 32'(-mb) : 32'(mb);
    psh  = pr_r >> FRAC_BITS;
    lim  = mneg_r ? 33'h080000000 : 33'h07fffffff;
    pc   = (psh > 66'(lim)) ? lim : psh[32:0];
    mres = mneg_r ? signed'(32'(-pc)) : signed'(pc[31:0]);
  end

  // basis weights, summed exactly
  logic signed [35:0] x36, x2e, x3e;
  assign x36 = 36'(x_r);
  assign x2e = 36'(x2_r);
  assign x3e = 36'(x3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r <= 7'd2;
    end else if (cfg_valid) begin
      kc_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        tq_r <= w_q;
        n_r  <= n_c;
      end
      OP_RD_LAST: begin
        tf_r <= rd_t_r;
        vf_r <= rd_v_r;
      end
      OP_CAP_LAST: begin
        tl_r <= rd_t_r;
        vl_r <= rd_v_r;
      end
      OP_CHECK: begin
        i_r    <= '0;
        prev_r <= tf_r;
        if (tq_r < tf_r) begin
          res_v_r <= vf_r;
          res_s_r <= RS_BELOW;
        end else begin
          res_v_r <= vl_r;
          res_s_r <= RS_ABOVE;
        end
      end
      OP_SCAN_CMP: begin
        priority if (sts.match) begin
          found_r <= 1'b1;
        end else if (sts.scan_end) begin
          found_r <= 1'b0;
          res_v_r <= vl_r;
          res_s_r <= RS_INTERP;
        end else begin
          i_r    <= i_r + NW'(1);
          prev_r <= rd_t_r;
        end
      end
      OP_SETUP: begin
        if (found_r) begin
          a_r    <= (i_r == '0) ? n_r - NW'(1) : i_r - NW'(1);
          b_r    <= i_r;
          c_r    <= i_r + NW'(1);
          wrap_r <= (i_r == n_r - NW'(2));
          d_r    <= (i_r == n_r - NW'(2)) ? '0 : i_r + NW'(2);
        end else begin
          a_r    <= n_r - NW'(2);
          b_r    <= n_r - NW'(1);
          c_r    <= '0;
          d_r    <= NW'(1);
          wrap_r <= 1'b0;
        end
      end
      OP_FETCH: begin
        unique case (cmd.sel)
          3'd1: begin t0_r <= rd_t_r; y0_r <= rd_v_r; end
          3'd2: begin t1_r <= rd_t_r; y1_r <= rd_v_r; end
          3'd3: begin t2_r <= rd_t_r; y2_r <= rd_v_r; end
          3'd4: begin
            t3_r <= wrap_r ? 33'(rd_t_r) + 33'(tl_r) : 33'(rd_t_r);
            y3_r <= rd_v_r;
          end
          default: ;
        endcase
      end
      OP_DIFF: begin
        h_r <= 34'(t2_r) - 34'(t1_r);
        e_r <= 34'(t2_r) - 34'(t0_r);
        g_r <= 34'(t3_r) - 34'(t1_r);
      end
      OP_ZCHK: begin
        res_v_r <= '0;
        res_s_r <= RS_ZERO;
      end
      OP_DIV_LD: begin
        rem_r  <= dd_c;
        vs_r   <= DIVW'(dmag) << 31;
        q_r    <= '0;
        dneg_r <= num_c[33] ^ den_c[33];
        dovf_r <= (dd_c >> 32) >= DIVW'(dmag);
      end
      OP_DIV_STEP: begin
        if (rem_r >= vs_r) rem_r <= rem_r - vs_r;
        q_r  <= {q_r[30:0], (rem_r >= vs_r)};
        vs_r <= vs_r >> 1;
      end
      OP_DIV_END: begin
        unique case (cmd.sel)
          3'd0:    x_r  <= div_res;
          3'd1:    m1_r <= div_res;
          default: m2_r <= div_res;
        endcase
      end
      OP_MUL_A: begin
        pr_r   <= 66'(amag) * 66'(bmag);
        mneg_r <= ma[33] ^ mb[31];
      end
      OP_MUL_B: begin
        unique case (cmd.sel)
          3'd0: x2_r  <= mres;
          3'd1: x3_r  <= mres;
          3'd2: d1_r  <= mres;
          3'd3: d2_r  <= mres;
          3'd4: acc_r <= 34'(mres);
          default: acc_r <= acc_r + 34'(mres);
        endcase
      end
      OP_BASIS: begin
        b00_r <= sat32(40'(2 * x3e - 3 * x2e + (36'sd1 << FRAC_BITS)));
        b10_r <= sat32(40'(x3e - 2 * x2e + x36));
        b01_r <= sat32(40'(3 * x2e - 2 * x3e));
        b11_r <= sat32(40'(x3e - x2e));
      end
      OP_FINAL: begin
        res_v_r <= sat32(40'(acc_r));
        res_s_r <= RS_INTERP;
      end
      default: ;
    endcase
  end

  // output register
  logic out_valid_r;
  logic [39:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) out_data_r <= {6'd0, res_s_r, res_v_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.below    = (tq_r < tf_r);
  assign sts.above    = (tq_r > tl_r);
  assign sts.match    = (tq_r >= prev_r) && (tq_r < rd_t_r);
  assign sts.scan_end = ((i_r + NW'(2)) == n_r);
  assign sts.eq_last  = (tq_r == tl_r);
  assign sts.zero_den = (h_r == '0) || (e_r == '0) || (g_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

// ===== design/cubic_hermite_knot_interpolator_unit.sv =====
// cubic hermite knot interpolator: a knot table of MAX_KNOTS entries (time and value, signed
// fixed point with FRAC_BITS fraction bits) is loaded one knot per write word (in_tuser 0);
// a query word (in_tuser 1) returns one result word with the spline value and a status
// (0 interpolated, 1 clamped below, 2 clamped above, 3 zero denominator). a query runs one at a
// time through the sequencer: it reads the end knots and clamps, runs the linear interval search
// over the single table read port, fetches the four neighbor knots and forms differences, then
// runs the three radix-2 divisions, four multiplies, the basis weights, four more multiplies and
// the final sum; clamped queries skip the search and the arithmetic. a finished result waits in
// the output register while the next word is accepted. knot_count is set over the cfg channel
// while the block is idle, a rule for the user that the block itself does not enforce; it reads
// 2 after reset.
module cubic_hermite_knot_interpolator_unit import chki_pkg::*; #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // cfg channel: knot_count
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata from bit 0: knot_index[5:0], knot_time[37:6], knot_value[69:38],
  // query_time[101:70], zero pad[103:102]
  input  logic [103:0] in_tdata,
  // in_tuser: action (0 write knot, 1 query)
  input  logic         in_tuser,
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata from bit 0: interpolated_value[31:0], status[33:32], zero pad[39:34]
  output logic [39:0]  out_tdata
);

  cmd_t cmd;
  sts_t sts;

  // config is always taken and the block does not wait for idle; knot writes only land while idle
  assign cfg_ready = 1'b1;

  chki_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chki_dp #(
    .MAX_KNOTS (MAX_KNOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chki_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic        act;
    logic [5:0]  idx;
    logic [31:0] ktime;
    logic [31:0] kval;
    logic [31:0] qtime;
  } knot_word_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } spline_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [6:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;

  // predictor state: knot table mirror and knot count
  int             mirror_time [TABLE_DEPTH];
  int             mirror_value [TABLE_DEPTH];
  logic [6:0]     mirror_count;
  spline_result_t pending_results[$];
  int             error_count = 0;
  // knot times the stimulus last loaded, used to aim queries
  longint         loaded_time [TABLE_DEPTH];

  cubic_hermite_knot_interpolator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, magnitude shifted down by the fraction bits, saturated
  function automatic longint fx_mul(longint a, longint b);
    logic         neg;
    longint       ua, ub, lim;
    logic [127:0] prod;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    lim = neg ? 64'sd2147483648 : 64'sd2147483647;
    if (ua == 0 || ub == 0) return 0;
    prod = (128'(ua) * 128'(ub)) >> 16;
    if (prod > 128'(lim)) prod = 128'(lim);
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // fixed point divide, truncates toward zero
  function automatic longint fx_div(longint num, longint den);
    return clip32((num * 65536) / den);
  endfunction

  // spline evaluation at one query time against the mirrored table
  function automatic spline_result_t eval_spline(logic [31:0] qt);
    spline_result_t r;
    int     n, a, b, c, d, i;
    longint t, t0, t1, t2, t3, y0, y1, y2, y3, h, x, x2, x3, m1, m2, d1, d2;
    longint w00, w10, w01, w11, acc;
    logic   found;
    n = mirror_count;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    t = longint'($signed(qt));
    r.status = RS_INTERP;
    if (t < mirror_time[0]) begin
      r.value = mirror_value[0];
      r.status = RS_BELOW;
      return r;
    end
    if (t > mirror_time[n-1]) begin
      r.value = mirror_value[n-1];
      r.status = RS_ABOVE;
      return r;
    end
    // no interval found: neighbors n-2, n-1, 0, 1 with plain times
    a = n - 2; b = n - 1; c = 0; d = 1;
    t3 = mirror_time[d];
    found = 1'b0;
    for (i = 0; i + 1 < n && !found; i++) begin
      if (t >= mirror_time[i] && t < mirror_time[i+1]) begin
        found = 1'b1;
        a = (i == 0) ? n - 1 : i - 1;
        b = i;
        c = i + 1;
        if (i == n - 2) begin
          // last interval wraps to knot 0, shifted by the last time
          d = 0;
          t3 = longint'(mirror_time[0]) + longint'(mirror_time[n-1]);
        end else begin
          d = i + 2;
          t3 = mirror_time[d];
        end
      end
    end
    if (!found && t == mirror_time[n-1]) begin
      r.value = mirror_value[n-1];
      return r;
    end
    t0 = mirror_time[a]; t1 = mirror_time[b]; t2 = mirror_time[c];
    y0 = mirror_value[a]; y1 = mirror_value[b]; y2 = mirror_value[c]; y3 = mirror_value[d];
    h = t2 - t1;
    if (h == 0 || t2 - t0 == 0 || t3 - t1 == 0) begin
      r.value = '0;
      r.status = RS_ZERO;
      return r;
    end
    x  = fx_div(t - t1, h);
    m1 = fx_div(y2 - y0, t2 - t0);
    m2 = fx_div(y3 - y1, t3 - t1);
    x2 = fx_mul(x, x);
    x3 = fx_mul(x2, x);
    d1 = fx_mul(h, m1);
    d2 = fx_mul(h, m2);
    w00 = clip32(2 * x3 - 3 * x2 + 65536);
    w10 = clip32(x3 - 2 * x2 + x);
    w01 = clip32(-2 * x3 + 3 * x2);
    w11 = clip32(x3 - x2);
    acc = clip32(fx_mul(w00, y1) + fx_mul(w10, d1) + fx_mul(w01, y2) + fx_mul(w11, d2));
    r.value = acc[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- monitor
  // one process sees every handshake, so prediction and checking share an edge cleanly
  always @(posedge clk) begin
    spline_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) mirror_count <= cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_WRITE) begin
          mirror_time[in_tdata[5:0]] = in_tdata[37:6];
          mirror_value[in_tdata[5:0]] = in_tdata[69:38];
        end else begin
          pending_results.push_back(eval_spline(in_tdata[101:70]));
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word value %h status %0d", $time,
                   out_tdata[31:0], out_tdata[33:32]);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[31:0] !== want.value) begin
            $display("%0t: value mismatch expected %h actual %h", $time, want.value,
                     out_tdata[31:0]);
            error_count++;
          end
          if (out_tdata[33:32] !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
                     out_tdata[33:32]);
            error_count++;
          end
        end
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure, with quiet stretches of steady ready
  initial begin
    int k;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        k = idle_len();
        if (k > 0) begin
          out_tready <= 1'b0;
          repeat (k) @(negedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // valid stays up between back-to-back words
  task automatic send_word(knot_word_t w);
    int k;
    k = idle_len();
    if (k > 0) begin
      in_tvalid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.act;
    in_tdata <= {2'b00, w.qtime, w.kval, w.ktime, w.idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_knot(int idx, longint kt, longint kv);
    knot_word_t w;
    w.act = ACT_WRITE;
    w.idx = idx[5:0];
    w.ktime = kt[31:0];
    w.kval = kv[31:0];
    w.qtime = $urandom;
    loaded_time[idx] = longint'($signed(kt[31:0]));
    send_word(w);
  endtask

  task automatic query_at(longint qt);
    knot_word_t w;
    w.act = ACT_QUERY;
    w.idx = 6'($urandom);
    w.ktime = $urandom;
    w.kval = $urandom;
    w.qtime = qt[31:0];
    send_word(w);
  endtask

  // hold the sender until every result is back and the sequencer has gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_knot_count(int n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= n[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  // fill the whole table once so no later query reads an unwritten knot
  task automatic test_table_fill();
    int k;
    for (k = 0; k < TABLE_DEPTH; k++)
      write_knot(k, (k - 8) * 64'sd262144, (k % 2) ? -k * 64'sd100000 : k * 64'sd70000);
  endtask

  task automatic test_directed();
    // two knots: inside always hits a zero denominator since the wrap neighbor is knot 1
    query_at(-64'sd2147483648);
    query_at(64'sd2147483647);
    query_at(loaded_time[0]);
    query_at(loaded_time[1]);
    query_at(loaded_time[0] + 100);
    // four knots with extreme values to force saturation
    set_knot_count(4);
    write_knot(0, -64'sd2147483648, 64'sd2147483647);
    write_knot(1, 64'sd65536, -64'sd2147483648);
    write_knot(2, 64'sd131072, 64'sd2147483647);
    write_knot(3, 64'sd2147483647, -64'sd2147483648);
    query_at(-64'sd2147483648);
    query_at(64'sd98304);
    query_at(64'sd131072);
    query_at(64'sd1000000000);
    query_at(64'sd2147483647);
    query_at(0);
    // duplicate time gives a zero-length interval
    write_knot(2, 64'sd65536, 64'sd5);
    query_at(64'sd65536);
    query_at(64'sd70000);
    // descending middle knots: both queries land in the first interval
    write_knot(1, 64'sd200000, 64'sd300);
    write_knot(2, 64'sd100000, -64'sd300);
    query_at(64'sd150000);
    query_at(64'sd50000);
  endtask

  // one random setting: reload the used knots, then a burst of queries
  task automatic run_phase(int cfg_n, int queries);
    int     n, k, pick, style;
    longint span, cur, kv, lo, hi;
    set_knot_count(cfg_n);
    n = (cfg_n < 2) ? 2 : (cfg_n > TABLE_DEPTH) ? TABLE_DEPTH : cfg_n;
    style = $urandom_range(0, 9);
    span = (style < 3) ? (64'sd4294967295 / (n + 1)) : 64'sd400000;
    cur = (style < 3) ? -64'sd2147483648 + $urandom_range(0, 1000)
                      : longint'($urandom_range(0, 2000000)) - 64'sd1000000;
    for (k = 0; k < n; k++) begin
      kv = ($urandom_range(0, 3) == 0) ? longint'($signed($urandom))
                                       : longint'($urandom_range(0, 2000000)) - 64'sd1000000;
      write_knot(k, cur, kv);
      if (style == 9 && $urandom_range(0, 3) == 0) cur = cur;           // repeated time
      else if (style == 8 && $urandom_range(0, 4) == 0) cur = cur - 5000; // out of order
      else cur = cur + $urandom_range(1, 32'(span));
    end
    lo = loaded_time[0];
    hi = loaded_time[n-1];
    for (k = 0; k < queries; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) query_at(lo - $urandom_range(1, 100000));
      else if (pick < 16) query_at(hi + $urandom_range(1, 100000));
      else if (pick < 24) query_at(loaded_time[$urandom_range(0, n - 1)]);
      else if (pick < 30) query_at(longint'($signed($urandom)));
      else begin
        cur = loaded_time[$urandom_range(0, n - 2)];
        span = loaded_time[$urandom_range(0, n - 1)] - cur;
        if (span < 0) span = -span;
        query_at(cur + ((span > 0) ? longint'($urandom) % span : 0));
      end
    end
  endtask

  task automatic test_random();
    int settings[] = '{0, 1, 2, 3, 5, 8, 16, 33, 64, 100, 127, 6, 12};
    foreach (settings[s]) run_phase(settings[s], 26);
  endtask

  initial begin
    mirror_count = 7'd2;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      mirror_time[k] = 0;
      mirror_value[k] = 0;
      loaded_time[k] = 0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_table_fill();
    test_directed();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
